/* rtl/dfhre_pkg.sv */
// Shared types and constants for the deflate fixed-Huffman run encoder.
package dfhre_pkg;

   localparam int COLUMN_BITS_DEFAULT = 16;
   localparam int MAX_BYTES           = 4;
   localparam int REQ_TDATA_W         = 24;
   localparam int RSP_TDATA_W         = 40;

   localparam logic [15:0] ROW_WIDTH_RESET = 16'd1;
   localparam logic [16:0] ADLER_MOD       = 17'd65521;
   localparam logic [31:0] ADLER_RESET     = 32'd1;

   typedef enum logic [1:0] {
      OP_PIXEL = 2'd0,
      OP_START = 2'd1,
      OP_PAD   = 2'd2
   } opcode_type;

   typedef struct packed {
      logic [15:0] column;
      logic [7:0]  pixel;
      opcode_type  opcode;
   } item_type;

   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [2:0]                count;
      logic [31:0]               adler;
   } bundle_type;

endpackage

/* rtl/deflate_fixed_huffman_run_encoder.sv */
// Top level of the deflate fixed-Huffman run encoder with running Adler-32.
// Items enter an input register, are encoded combinationally against the run,
// bit-packing and Adler state, and land in a result register that sends one
// byte per transfer. An item that yields zero or one byte needs one transfer, so
// such items stream at one per cycle while rsp_tready stays high; an item that
// closes a run and yields k bytes (up to four) holds the result port for k
// transfers. row_width resets to 1; the user must write it only while the
// block is idle, and the block itself does not enforce this.
module deflate_fixed_huffman_run_encoder #(
   parameter int COLUMN_BITS = dfhre_pkg::COLUMN_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // pixel[7:0], column[23:8]
   input  logic [dfhre_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // opcode[1:0]
   input  logic [1:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // out_byte[7:0], adler[39:8]
   output logic [dfhre_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // byte_valid[0]
   output logic                               rsp_tuser,
   output logic                               rsp_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [15:0]                        csr_data
);

   logic                  in_valid_ff, in_valid_in;
   dfhre_pkg::item_type   in_item_ff, in_item_in;
   logic [15:0]           row_width_ff;
   logic                  emit_free;
   logic                  fire;
   logic                  adler_en;
   logic [31:0]           adler_next;
   dfhre_pkg::bundle_type bundle;

   assign csr_ready  = 1'b1;
   assign fire       = in_valid_ff && emit_free;
   assign req_tready = !in_valid_ff || emit_free;
   assign adler_en   = fire && ((in_item_ff.opcode == dfhre_pkg::OP_PIXEL) ||
                                (in_item_ff.opcode == dfhre_pkg::OP_START));

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in       = 1'b1;
         in_item_in.column = req_tdata[23:8];
         in_item_in.pixel  = req_tdata[7:0];
         in_item_in.opcode = dfhre_pkg::opcode_type'(req_tuser);
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         row_width_ff <= dfhre_pkg::ROW_WIDTH_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_valid && csr_ready) begin
            row_width_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
   end

   dfhre_adler u_adler (
      .clock     (clock),
      .reset     (reset),
      .upd_en    (adler_en),
      .upd_byte  (in_item_ff.pixel),
      .adler_out (adler_next)
   );

   dfhre_encode #(
      .COLUMN_BITS (COLUMN_BITS)
   ) u_encode (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (in_item_ff),
      .row_width (row_width_ff),
      .adler     (adler_next),
      .bundle    (bundle)
   );

   dfhre_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .bundle_in  (bundle),
      .free       (emit_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("result without byte is not the last of its item");

   a_held_item: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |=> in_valid_ff && $stable(in_item_ff))
      else $error("waiting input item lost or changed");

   a_byte_count: assert property (@(posedge clock) disable iff (reset)
      fire |-> bundle.count <= 3'd4)
      else $error("more than four bytes from one item");

   a_pad_one_byte: assert property (@(posedge clock) disable iff (reset)
      fire && (in_item_ff.opcode == dfhre_pkg::OP_PAD) |-> bundle.count <= 3'd1)
      else $error("pad produced more than one byte");

endmodule

/* rtl/dfhre_adler.sv */
// Running Adler-32 register with single-byte modular update.
module dfhre_adler (
   input  logic        clock,
   input  logic        reset,
   input  logic        upd_en,
   input  logic [7:0]  upd_byte,
   output logic [31:0] adler_out
);

   logic [31:0] adler_ff;
   logic [31:0] adler_in;
   logic [16:0] s1_sum;
   logic [15:0] s1_red;
   logic [16:0] s2_sum;
   logic [15:0] s2_red;

   always_comb begin
      s1_sum = 17'(adler_ff[15:0]) + 17'(upd_byte);
      s1_red = (s1_sum >= dfhre_pkg::ADLER_MOD) ? 16'(s1_sum - dfhre_pkg::ADLER_MOD)
                                                : s1_sum[15:0];
      s2_sum = 17'(adler_ff[31:16]) + 17'(s1_red);
      s2_red = (s2_sum >= dfhre_pkg::ADLER_MOD) ? 16'(s2_sum - dfhre_pkg::ADLER_MOD)
                                                : s2_sum[15:0];
      adler_in = upd_en ? {s2_red, s1_red} : adler_ff;
   end

   assign adler_out = adler_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         adler_ff <= dfhre_pkg::ADLER_RESET;
      end else begin
         adler_ff <= adler_in;
      end
   end

endmodule

/* rtl/dfhre_encode.sv */
// Run tracking, fixed-Huffman code generation and LSB-first bit packing.
module dfhre_encode #(
   parameter int COLUMN_BITS = dfhre_pkg::COLUMN_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  dfhre_pkg::item_type    item,
   input  logic [15:0]            row_width,
   input  logic [31:0]            adler,
   output dfhre_pkg::bundle_type  bundle
);

   localparam logic [31:0] ColMask = 32'((64'd1 << COLUMN_BITS) - 64'd1);

   // pending bits, first bit in bit 0, bits above the count kept zero
   logic [6:0] acc_ff, acc_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [8:0] run_value_ff, run_value_in;
   logic [8:0] run_repeats_ff, run_repeats_in;

   logic [12:0] lit_pix, lit_run;
   logic [17:0] part_a;
   logic [4:0]  len_a;
   logic [26:0] stream;
   logic [4:0]  stream_len;
   logic [33:0] total;
   logic [5:0]  sum_bits;
   logic        close;
   logic [31:0] col_m, last_m;

   function automatic logic [8:0] rev_code(input logic [8:0] code, input logic [3:0] n);
      logic [8:0] r;
      for (int i = 0; i < 9; i++) begin
         r[i] = code[8-i];
      end
      return r >> (4'd9 - n);
   endfunction

   // returns {length, bits in stream order}
   function automatic logic [12:0] lit_bits(input logic [7:0] b);
      logic [8:0] code;
      logic [3:0] n;
      if (b < 8'd144) begin
         code = 9'd48 + 9'(b);
         n    = 4'd8;
      end else begin
         code = 9'd400 + 9'(b - 8'd144);
         n    = 4'd9;
      end
      return {n, rev_code(code, n)};
   endfunction

   logic [17:0] len_stream;
   logic [4:0]  len_stream_n;

   always_comb begin
      lit_pix = lit_bits(item.pixel);
      lit_run = lit_bits(run_value_ff[7:0]);
      col_m   = 32'(item.column) & ColMask;
      last_m  = (32'(row_width) - 32'd1) & ColMask;
      close   = (9'(item.pixel) != run_value_ff) || (run_repeats_ff > 9'd256) ||
                (col_m == last_m);

      len_stream   = '0;
      len_stream_n = '0;
      // length symbol, extra bits and the five-bit distance code zero
      begin : length_part
         logic [8:0]  sym;
         logic [2:0]  xn;
         logic [8:0]  code;
         logic [3:0]  n;
         sym = '0;
         xn  = '0;
         if (run_repeats_ff < 9'd11) begin
            sym = 9'd254 + run_repeats_ff;
         end else if (run_repeats_ff < 9'd19) begin
            sym = 9'd265 + ((run_repeats_ff - 9'd11) >> 1);
            xn  = 3'd1;
         end else if (run_repeats_ff < 9'd35) begin
            sym = 9'd269 + ((run_repeats_ff - 9'd19) >> 2);
            xn  = 3'd2;
         end else if (run_repeats_ff < 9'd67) begin
            sym = 9'd273 + ((run_repeats_ff - 9'd35) >> 3);
            xn  = 3'd3;
         end else if (run_repeats_ff < 9'd131) begin
            sym = 9'd277 + ((run_repeats_ff - 9'd67) >> 4);
            xn  = 3'd4;
         end else begin
            sym = 9'd281 + ((run_repeats_ff - 9'd131) >> 5);
            xn  = 3'd5;
         end
         if (sym < 9'd280) begin
            code = sym - 9'd256;
            n    = 4'd7;
         end else begin
            code = 9'd192 + (sym - 9'd280);
            n    = 4'd8;
         end
         len_stream = 18'(rev_code(code, n)) |
                      (18'(5'(run_repeats_ff - 9'd3) & 5'((6'd1 << xn) - 6'd1)) << n);
         len_stream_n = 5'(n) + 5'(xn) + 5'd5;
      end

      if (run_repeats_ff > 9'd2) begin
         part_a = len_stream;
         len_a  = len_stream_n;
      end else if (run_repeats_ff == 9'd2) begin
         part_a = 18'(lit_run[8:0]) | (18'(lit_run[8:0]) << lit_run[12:9]);
         len_a  = 5'(lit_run[12:9]) + 5'(lit_run[12:9]);
      end else if (run_repeats_ff == 9'd1) begin
         part_a = 18'(lit_run[8:0]);
         len_a  = 5'(lit_run[12:9]);
      end else begin
         part_a = '0;
         len_a  = '0;
      end
   end

   always_comb begin
      stream         = '0;
      stream_len     = '0;
      run_value_in   = run_value_ff;
      run_repeats_in = run_repeats_ff;
      unique case (item.opcode)
         dfhre_pkg::OP_START: begin
            stream         = 27'(lit_pix[8:0]);
            stream_len     = 5'(lit_pix[12:9]);
            run_value_in   = 9'd256;
            run_repeats_in = '0;
         end
         dfhre_pkg::OP_PIXEL: begin
            if (close) begin
               stream         = 27'(part_a) | (27'(lit_pix[8:0]) << len_a);
               stream_len     = len_a + 5'(lit_pix[12:9]);
               run_value_in   = 9'(item.pixel);
               run_repeats_in = '0;
            end else begin
               run_repeats_in = run_repeats_ff + 9'd1;
            end
         end
         default: begin
         end
      endcase

      total    = 34'(acc_ff) | (34'(stream) << cnt_ff);
      sum_bits = 6'(cnt_ff) + 6'(stream_len);

      bundle.adler = adler;
      bundle.bytes = total[31:0];
      bundle.count = sum_bits[5:3];
      acc_in       = 7'(total >> {sum_bits[5:3], 3'b000});
      cnt_in       = sum_bits[2:0];

      if (item.opcode == dfhre_pkg::OP_PAD) begin
         bundle.bytes = 32'(acc_ff);
         bundle.count = (cnt_ff != 3'd0) ? 3'd1 : 3'd0;
         acc_in       = '0;
         cnt_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff         <= '0;
         cnt_ff         <= '0;
         run_value_ff   <= 9'd256;
         run_repeats_ff <= '0;
      end else if (fire) begin
         acc_ff         <= acc_in;
         cnt_ff         <= cnt_in;
         run_value_ff   <= run_value_in;
         run_repeats_ff <= run_repeats_in;
      end
   end

endmodule

/* rtl/dfhre_emit.sv */
// Result register that sends the bytes of one encoded item, one per transfer.
module dfhre_emit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  dfhre_pkg::bundle_type               bundle_in,
   output logic                                free,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dfhre_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);

   logic                   valid_ff, valid_in;
   dfhre_pkg::bundle_type  bundle_ff, bundle_in_sel;
   logic [1:0]             idx_ff, idx_in;
   logic                   last_item;
   logic                   byte_valid;
   logic [7:0]             out_byte;
   logic                   xfer;

   always_comb begin
      last_item  = bundle_ff.count <= (3'({1'b0, idx_ff}) + 3'd1);
      byte_valid = {1'b0, idx_ff} < bundle_ff.count;
      out_byte   = byte_valid ? bundle_ff.bytes[idx_ff] : 8'd0;
      xfer       = valid_ff && rsp_tready;
      free       = !valid_ff || (xfer && last_item);

      valid_in      = valid_ff;
      idx_in        = idx_ff;
      bundle_in_sel = bundle_ff;
      if (load) begin
         valid_in      = 1'b1;
         idx_in        = '0;
         bundle_in_sel = bundle_in;
      end else if (xfer && last_item) begin
         valid_in = 1'b0;
      end else if (xfer) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_item;
   assign rsp_tuser  = byte_valid;
   assign rsp_tdata  = {bundle_ff.adler, out_byte};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      bundle_ff <= bundle_in_sel;
   end

endmodule

/* sim/tb_deflate_fixed_huffman_run_encoder.sv */
// Self-checking testbench for the deflate fixed-Huffman run encoder with Adler-32.
module tb_deflate_fixed_huffman_run_encoder;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         NDIR        = 24;
   localparam int         QUIET_LIMIT = 2000;
   localparam int         HOLD_CYCLES = 300;
   localparam int         DRAIN_WAIT  = 4;

   typedef struct packed {
      logic [7:0]  code_byte;
      logic        byte_valid;
      logic [31:0] adler;
      logic        last;
   } coded_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  pix;
      logic [15:0] col;
      logic        typed;
      logic [7:0]  t_byte;
      logic        t_valid;
      logic [31:0] t_adler;
   } stim_type;

   // typed rows: first transfers after reset, 8-bit and 9-bit literal extremes
   localparam stim_type DIR_TAB [NDIR] = '{
      '{dfhre_pkg::OP_PAD,   8'h00, 16'd0,     1'b1, 8'h00, 1'b0, 32'h0000_0001},
      '{OP_UNUSED,           8'h5A, 16'd3,     1'b1, 8'h00, 1'b0, 32'h0000_0001},
      '{dfhre_pkg::OP_START, 8'h00, 16'd0,     1'b1, 8'h0C, 1'b1, 32'h0001_0001},
      '{dfhre_pkg::OP_PAD,   8'h00, 16'd0,     1'b1, 8'h00, 1'b0, 32'h0001_0001},
      '{dfhre_pkg::OP_START, 8'hFF, 16'd0,     1'b1, 8'hFF, 1'b1, 32'h0101_0100},
      '{dfhre_pkg::OP_PAD,   8'h00, 16'd0,     1'b1, 8'h01, 1'b1, 32'h0101_0100},
      '{dfhre_pkg::OP_PIXEL, 8'd7,  16'd1,     1'b0, 8'h00, 1'b0, 32'h0},
      '{dfhre_pkg::OP_PIXEL, 8'd7,  16'd2,     1'b0, 8'h00, 1'b0, 32'h0},
      '{dfhre_pkg::OP_PIXEL, 8'd7,  16'd3,     1'b0, 8'h00, 1'b0, 32'h0},
      '{dfhre_pkg::OP_PIXEL, 8'd7,  16'd4,     1'b0, 8'h00, 1'b0, 32'h0},
      '{dfhre_pkg::OP_PIXEL, 8'd9,  16'd5,     1'b0, 8'h00, 1'b0, 32'h0},
      '{dfhre_pkg::OP_PIXEL, 8'd9,  16'd6,     1'b0, 8'h00, 1'b0, 32'h0},
      '{dfhre_pkg::OP_PIXEL, 8'd9,  16'd7,     1'b0, 8'h00, 1'b0, 32'h0},
      '{dfhre_pkg::OP_PIXEL, 8'd200, 16'hFFFF, 1'b0, 8'h00, 1'b0, 32'h0},
      '{dfhre_pkg::OP_PIXEL, 8'd200, 16'd0,    1'b0, 8'h00, 1'b0, 32'h0},
      '{dfhre_pkg::OP_PIXEL, 8'd200, 16'd9,    1'b0, 8'h00, 1'b0, 32'h0},
      '{dfhre_pkg::OP_START, 8'd143, 16'd0,    1'b0, 8'h00, 1'b0, 32'h0},
      '{dfhre_pkg::OP_PIXEL, 8'd143, 16'd1,    1'b0, 8'h00, 1'b0, 32'h0},
      '{dfhre_pkg::OP_PIXEL, 8'd143, 16'd2,    1'b0, 8'h00, 1'b0, 32'h0},
      '{dfhre_pkg::OP_START, 8'd144, 16'd0,    1'b0, 8'h00, 1'b0, 32'h0},
      '{dfhre_pkg::OP_PIXEL, 8'd144, 16'd0,    1'b0, 8'h00, 1'b0, 32'h0},
      '{OP_UNUSED,           8'hAA, 16'hFFFF,  1'b0, 8'h00, 1'b0, 32'h0},
      '{dfhre_pkg::OP_PAD,   8'h3C, 16'h1234,  1'b0, 8'h00, 1'b0, 32'h0},
      '{dfhre_pkg::OP_PAD,   8'hC3, 16'hEDCB,  1'b0, 8'h00, 1'b0, 32'h0}
   };

   logic                              clock;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [dfhre_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic [1:0]                        req_tuser;
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic [dfhre_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                              rsp_tuser;
   logic                              rsp_tlast;
   logic                              csr_valid;
   logic                              csr_ready;
   logic [15:0]                       csr_data;

   deflate_fixed_huffman_run_encoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // encoder state as predicted
   logic [15:0] row_w;
   logic [7:0]  bit_buf;
   int          bit_cnt;
   logic [8:0]  run_val;
   int          run_reps;
   logic [31:0] adler_q;

   coded_type   encoded[$];
   coded_type   bytes_due[$];

   bit          gaps_on;
   bit          stall_on;
   bit          hold_rsp;
   int          errors;
   int          items_sent;
   int          results_seen;
   int          max_reps;
   int          widths_used;
   int          quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void push_bit(logic b);
      bit_buf = {b, bit_buf[7:1]};
      bit_cnt++;
      if (bit_cnt == 8) begin
         encoded.push_back('{bit_buf, 1'b1, 32'h0, 1'b0});
         bit_cnt = 0;
      end
   endfunction

   function automatic void put_code(int n, int code);
      for (int i = n - 1; i >= 0; i--) push_bit(code[i]);
   endfunction

   function automatic void put_extra(int n, int val);
      for (int i = 0; i < n; i++) push_bit(val[i]);
   endfunction

   function automatic void put_symbol(int sym);
      if (sym < 144) put_code(8, 48 + sym);
      else if (sym < 256) put_code(9, 400 + sym - 144);
      else if (sym < 280) put_code(7, sym - 256);
      else put_code(8, 192 + sym - 280);
   endfunction

   function automatic void put_length(int len);
      if (len < 11) begin
         put_symbol(254 + len);
      end else if (len < 19) begin
         put_symbol(265 + (len - 11) / 2);
         put_extra(1, (len - 3) % 2);
      end else if (len < 35) begin
         put_symbol(269 + (len - 19) / 4);
         put_extra(2, (len - 3) % 4);
      end else if (len < 67) begin
         put_symbol(273 + (len - 35) / 8);
         put_extra(3, (len - 3) % 8);
      end else if (len < 131) begin
         put_symbol(277 + (len - 67) / 16);
         put_extra(4, (len - 3) % 16);
      end else if (len < 258) begin
         put_symbol(281 + (len - 131) / 32);
         put_extra(5, (len - 3) % 32);
      end else begin
         put_symbol(285);
      end
   endfunction

   function automatic void adler_add(logic [7:0] b);
      int s1;
      int s2;
      s1 = adler_q[15:0] + b;
      s2 = adler_q[31:16] + s1;
      s1 = s1 % int'(dfhre_pkg::ADLER_MOD);
      s2 = s2 % int'(dfhre_pkg::ADLER_MOD);
      adler_q = {s2[15:0], s1[15:0]};
   endfunction

   // fills encoded with the transfers one input produces
   function automatic void deflate_encode(logic [1:0] op, logic [7:0] pix, logic [15:0] col);
      logic [15:0] last_col;
      last_col = row_w - 16'd1;
      encoded.delete();
      case (op)
         dfhre_pkg::OP_START: begin
            adler_add(pix);
            put_symbol(pix);
            run_val  = 9'd256;
            run_reps = 0;
         end
         dfhre_pkg::OP_PAD: begin
            if (bit_cnt != 0) begin
               while (bit_cnt != 8) begin
                  bit_buf = bit_buf >> 1;
                  bit_cnt++;
               end
               encoded.push_back('{bit_buf, 1'b1, 32'h0, 1'b0});
            end
            bit_cnt = 0;
         end
         dfhre_pkg::OP_PIXEL: begin
            adler_add(pix);
            if ({1'b0, pix} != run_val || run_reps > 256 || col == last_col) begin
               if (run_reps > 2) begin
                  put_length(run_reps);
                  put_extra(5, 0);
               end else begin
                  for (int i = 0; i < run_reps; i++) put_symbol(run_val);
               end
               run_val = {1'b0, pix};
               put_symbol(pix);
               run_reps = 0;
            end else begin
               run_reps++;
               if (run_reps > max_reps) max_reps = run_reps;
            end
         end
         default: ;
      endcase
      if (encoded.size() == 0) encoded.push_back('{8'h00, 1'b0, 32'h0, 1'b0});
      foreach (encoded[i]) begin
         encoded[i].adler = adler_q;
         encoded[i].last  = (i == encoded.size() - 1);
      end
   endfunction

   task automatic report(string what, longint got, longint want);
      if (errors < 50)
         $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
      errors++;
   endtask

   task automatic send_item(logic [1:0] op, logic [7:0] pix, logic [15:0] col,
                            logic typed = 1'b0, coded_type t_out = '0);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {col, pix};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      deflate_encode(op, pix, col);
      if (typed) bytes_due.push_back(t_out);
      else foreach (encoded[i]) bytes_due.push_back(encoded[i]);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_row_width(logic [15:0] w);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= w;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      row_w = w;
      widths_used++;
   endtask

   // mostly rows of runs with random content, mixed with start, pad and noise
   task automatic random_burst(int count, int start_col);
      int         col;
      int         run_left;
      int         sel;
      logic [7:0] val;
      col      = start_col;
      run_left = 0;
      val      = 8'($urandom);
      repeat (count) begin
         sel = $urandom_range(0, 99);
         if (sel < 8) begin
            send_item(dfhre_pkg::OP_START, 8'($urandom), 16'($urandom));
         end else if (sel < 14) begin
            send_item(dfhre_pkg::OP_PAD, 8'($urandom), 16'($urandom));
         end else if (sel < 17) begin
            send_item(OP_UNUSED, 8'($urandom), 16'($urandom));
         end else begin
            if (run_left == 0) begin
               val = 8'($urandom);
               run_left = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 140)
                                                       : $urandom_range(1, 8);
            end
            run_left--;
            if (sel < 20) send_item(dfhre_pkg::OP_PIXEL, val, 16'($urandom));
            else send_item(dfhre_pkg::OP_PIXEL, val, col[15:0]);
            col = (col + 1) & 16'hFFFF;
            if (row_w != 0 && col >= row_w) col = 0;
         end
      end
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
            rsp_tready <= 1'b1;
         end else if (stall_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      coded_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (bytes_due.size() == 0) begin
            report("transfer with nothing due", rsp_tdata, 0);
         end else begin
            want = bytes_due.pop_front();
            if (rsp_tdata[7:0] !== want.code_byte) report("out_byte", rsp_tdata[7:0], want.code_byte);
            if (rsp_tuser !== want.byte_valid) report("byte_valid", rsp_tuser, want.byte_valid);
            if (rsp_tdata[39:8] !== want.adler) report("adler", rsp_tdata[39:8], want.adler);
            if (rsp_tlast !== want.last) report("last", rsp_tlast, want.last);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      csr_valid    = 1'b0;
      csr_data     = '0;
      gaps_on      = 1'b1;
      stall_on     = 1'b1;
      hold_rsp     = 1'b0;
      errors       = 0;
      items_sent   = 0;
      results_seen = 0;
      max_reps     = 0;
      widths_used  = 0;
      row_w        = dfhre_pkg::ROW_WIDTH_RESET;
      bit_buf      = '0;
      bit_cnt      = 0;
      run_val      = 9'd256;
      run_reps     = 0;
      adler_q      = dfhre_pkg::ADLER_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NDIR; i++)
         send_item(DIR_TAB[i].op, DIR_TAB[i].pix, DIR_TAB[i].col, DIR_TAB[i].typed,
                   '{DIR_TAB[i].t_byte, DIR_TAB[i].t_valid, DIR_TAB[i].t_adler, 1'b1});

      // zero width: last column is 0xFFFF, so a long row hits the repeat cap
      write_row_width(16'd0);
      for (int i = 0; i < 262; i++) send_item(dfhre_pkg::OP_PIXEL, 8'h5C, i[15:0]);
      random_burst(20, 300);

      write_row_width(16'hFFFF);
      random_burst(20, 65530);

      write_row_width(16'd5);
      hold_rsp = 1'b1;
      random_burst(15, 0);
      wait_drained();
      random_burst(15, 0);

      write_row_width(16'd1);
      random_burst(15, 0);

      write_row_width(16'($urandom_range(2, 64)));
      random_burst(15, 0);

      gaps_on  = 1'b0;
      stall_on = 1'b0;
      write_row_width(16'($urandom_range(1, 300)));
      random_burst(20, 0);

      wait_drained();
      repeat (8) @(posedge clock);
      $display("covered %0d input transfers, %0d result transfers, %0d errors",
               items_sent, results_seen, errors);
      $display("row widths written: %0d (0, 65535, 1 among them); longest run %0d repeats",
               widths_used, max_reps);
      if (errors == 0 && bytes_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
